FILE: rtl/buddy_page_allocator_unit_defines.svh
// ---------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Shared checking macros for the allocator's concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define BPA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bpa_pkg.sv
// ---------------------------------------------------------------------------
// Buddy page allocator package
// Command and status codes, default sizes and the request and response types.
// ---------------------------------------------------------------------------
package bpa_pkg;

    // Default sizes.
    localparam int MAX_ORDER_DEF  = 11;
    localparam int FRAME_BITS_DEF = 20;
    localparam int LIST_DEPTH_DEF = 1024;

    // Field widths of the transactions.
    localparam int CMD_W    = 2;
    localparam int PAGE_W   = 20;
    localparam int ORDER_W  = 4;
    localparam int STATUS_W = 3;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC_AT = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OOM     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFREE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [PAGE_W-1:0]  page;
        logic [ORDER_W-1:0] order;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page;
    } t_rsp;

endpackage

FILE: rtl/bpa_list_mem.sv
// ---------------------------------------------------------------------------
// Free list memory
// Single-port-write, single-port-read RAM with a registered read.
// ---------------------------------------------------------------------------
module bpa_list_mem #(
    parameter int DW    = 20,
    parameter int AW    = 14,
    parameter int DEPTH = 11264
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  logic [DW-1:0] i_wd,
    input  logic [AW-1:0] i_ra,
    output logic [DW-1:0] o_rd
);

    logic [DW-1:0] r_mem [0:DEPTH-1];
    logic [DW-1:0] r_rd;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_ra];
    end

    assign o_rd = r_rd;

endmodule

FILE: rtl/bpa_seq.sv
// ---------------------------------------------------------------------------
// Buddy allocator sequencer
// Runs allocate, free and allocate-at as read-modify-write steps on the
// free list memory and keeps the per-order list counts.
// ---------------------------------------------------------------------------
module bpa_seq #(
    parameter int MAX_ORDER  = 11,
    parameter int FRAME_BITS = 20,
    parameter int LIST_DEPTH = 1024,
    parameter int OW         = 4,
    parameter int IW         = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  bpa_pkg::t_req         i_req,
    output logic                  o_busy,
    output logic                  o_rsp_vld,
    input  logic                  i_rsp_take,
    output bpa_pkg::t_rsp         o_rsp,
    output logic                  o_mem_we,
    output logic [OW+IW-1:0]      o_mem_wa,
    output logic [FRAME_BITS-1:0] o_mem_wd,
    output logic [OW+IW-1:0]      o_mem_ra,
    input  logic [FRAME_BITS-1:0] i_mem_rd
);
    import bpa_pkg::*;

    localparam int FB = FRAME_BITS;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int SW = 5;

    localparam logic [SW-1:0] S_IDLE     = 5'd0;
    localparam logic [SW-1:0] S_SRCH     = 5'd1;
    localparam logic [SW-1:0] S_F_LOOP   = 5'd2;
    localparam logic [SW-1:0] S_F_SRES   = 5'd3;
    localparam logic [SW-1:0] S_F_CHK    = 5'd4;
    localparam logic [SW-1:0] S_F_RM     = 5'd5;
    localparam logic [SW-1:0] S_F_RM2    = 5'd6;
    localparam logic [SW-1:0] S_FREE_END = 5'd7;
    localparam logic [SW-1:0] S_A_START  = 5'd8;
    localparam logic [SW-1:0] S_A_POP    = 5'd9;
    localparam logic [SW-1:0] S_A_SPL    = 5'd10;
    localparam logic [SW-1:0] S_P_LOOP   = 5'd11;
    localparam logic [SW-1:0] S_P_SRES   = 5'd12;
    localparam logic [SW-1:0] S_P_RM2    = 5'd13;
    localparam logic [SW-1:0] S_P_SPL    = 5'd14;
    localparam logic [SW-1:0] S_P_FRET   = 5'd15;
    localparam logic [SW-1:0] S_DONE     = 5'd16;

    localparam logic [FB-1:0] ONE_FB = FB'(1);
    localparam logic [CW-1:0] CNT_FULL = CW'(LIST_DEPTH);

    logic [SW-1:0]   r_state, n_state;
    logic [SW-1:0]   r_sret, r_fret;
    logic [CW-1:0]   r_cnt [0:MAX_ORDER-1];
    logic [IW-1:0]   r_pos [0:MAX_ORDER-1];
    logic [OW-1:0]   r_ord, r_ford, r_k, r_j, r_sk, r_pk;
    logic [FB-1:0]   r_a, r_tgt, r_p, r_base, r_res;
    logic [CW-1:0]   r_si;
    logic [IW-1:0]   r_ci, r_fpos;
    logic            r_cv, r_fnd;
    logic [STATUS_W-1:0] r_st, r_fst;

    logic [FB+PAGE_W-1:0] page_ext, res_ext;
    logic [FB-1:0]   page_m, upper;
    logic            ord_bad;
    logic [OW-1:0]   cnt_ra, kf, kk;
    logic            kf_ok, full_below;
    logic [CW-1:0]   cnt_rd, cnt_wd;
    logic            cnt_we;
    logic [OW-1:0]   cnt_wa;

    // Input page masked to the frame width, result page cut to the port width.
    assign page_ext = {{FB{1'b0}}, i_req.page};
    assign page_m   = page_ext[FB-1:0];
    assign res_ext  = {{PAGE_W{1'b0}}, r_res};
    assign ord_bad  = (32'(i_req.order) >= MAX_ORDER);

    // Lowest non-empty order at or above the request, and full lists below
    // the allocate-at order.
    always_comb begin
        kf = '0;
        kf_ok = 1'b0;
        full_below = 1'b0;
        for (int k = MAX_ORDER - 1; k >= 0; k--) begin
            if (k >= int'(r_ord) && r_cnt[k] != '0) begin
                kf = OW'(k);
                kf_ok = 1'b1;
            end
            if (k < int'(r_pk) && r_cnt[k] >= CNT_FULL) begin
                full_below = 1'b1;
            end
        end
    end

    assign kk     = (r_state == S_A_SPL) ? (r_k - OW'(1)) : (r_pk - OW'(1));
    assign upper  = r_base + (ONE_FB << kk);
    assign cnt_rd = r_cnt[cnt_ra];

    // Memory and count port control, next state.
    always_comb begin
        n_state  = r_state;
        cnt_ra   = r_k;
        cnt_we   = 1'b0;
        cnt_wa   = r_k;
        cnt_wd   = cnt_rd;
        o_mem_we = 1'b0;
        o_mem_wa = {r_k, IW'(cnt_rd)};
        o_mem_wd = r_a;
        o_mem_ra = {r_sk, IW'(r_si)};
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_req.cmd == CMD_ALLOC) begin
                        n_state = ord_bad ? S_DONE : S_A_START;
                    end else if (i_req.cmd == CMD_FREE) begin
                        n_state = ord_bad ? S_DONE : S_F_LOOP;
                    end else if (i_req.cmd == CMD_ALLOC_AT) begin
                        n_state = S_P_LOOP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SRCH: begin
                cnt_ra = r_sk;
                if (r_cv && i_mem_rd == r_tgt) begin
                    n_state = r_sret;
                end else if (r_si < cnt_rd) begin
                    n_state = S_SRCH;
                end else if (!r_cv) begin
                    n_state = r_sret;
                end
            end
            S_F_LOOP: begin
                n_state = (32'(r_k) < MAX_ORDER - 1) ? S_SRCH : S_F_CHK;
            end
            S_F_SRES: begin
                n_state = r_fnd ? S_F_LOOP : S_F_CHK;
            end
            S_F_CHK: begin
                cnt_ra  = r_k;
                n_state = (cnt_rd >= CNT_FULL) ? r_fret : S_F_RM;
            end
            S_F_RM: begin
                if (r_j < r_k) begin
                    cnt_ra   = r_j;
                    cnt_we   = 1'b1;
                    cnt_wa   = r_j;
                    cnt_wd   = cnt_rd - CW'(1);
                    o_mem_ra = {r_j, IW'(cnt_rd - CW'(1))};
                    n_state  = S_F_RM2;
                end else begin
                    cnt_ra   = r_k;
                    cnt_we   = 1'b1;
                    cnt_wa   = r_k;
                    cnt_wd   = cnt_rd + CW'(1);
                    o_mem_we = 1'b1;
                    o_mem_wa = {r_k, IW'(cnt_rd)};
                    o_mem_wd = r_a;
                    n_state  = r_fret;
                end
            end
            S_F_RM2: begin
                o_mem_we = 1'b1;
                o_mem_wa = {r_j, r_pos[r_j]};
                o_mem_wd = i_mem_rd;
                n_state  = S_F_RM;
            end
            S_FREE_END: begin
                n_state = S_DONE;
            end
            S_A_START: begin
                cnt_ra = kf;
                if (kf_ok) begin
                    cnt_we   = 1'b1;
                    cnt_wa   = kf;
                    cnt_wd   = cnt_rd - CW'(1);
                    o_mem_ra = {kf, IW'(cnt_rd - CW'(1))};
                    n_state  = S_A_POP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_A_POP: begin
                n_state = S_A_SPL;
            end
            S_A_SPL: begin
                cnt_ra = kk;
                if (r_k > r_ord) begin
                    cnt_we   = 1'b1;
                    cnt_wa   = kk;
                    cnt_wd   = cnt_rd + CW'(1);
                    o_mem_we = 1'b1;
                    o_mem_wa = {kk, IW'(cnt_rd)};
                    o_mem_wd = r_a + (ONE_FB << kk);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_P_LOOP: begin
                n_state = S_SRCH;
            end
            S_P_SRES: begin
                cnt_ra = r_pk;
                if (r_fnd) begin
                    if (full_below) begin
                        n_state = S_DONE;
                    end else begin
                        cnt_we   = 1'b1;
                        cnt_wa   = r_pk;
                        cnt_wd   = cnt_rd - CW'(1);
                        o_mem_ra = {r_pk, IW'(cnt_rd - CW'(1))};
                        n_state  = S_P_RM2;
                    end
                end else begin
                    n_state = (r_pk == '0) ? S_DONE : S_P_LOOP;
                end
            end
            S_P_RM2: begin
                o_mem_we = 1'b1;
                o_mem_wa = {r_pk, r_fpos};
                o_mem_wd = i_mem_rd;
                n_state  = S_P_SPL;
            end
            S_P_SPL: begin
                n_state = (r_pk != '0) ? S_F_LOOP : S_DONE;
            end
            S_P_FRET: begin
                n_state = S_P_SPL;
            end
            S_DONE: begin
                if (i_rsp_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register and list counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (cnt_we) begin
                r_cnt[cnt_wa] <= cnt_wd;
            end
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ord <= OW'(i_req.order);
                r_res <= '0;
                if (i_req.cmd == CMD_ALLOC) begin
                    r_st <= ST_BAD;
                end else if (i_req.cmd == CMD_FREE) begin
                    r_st   <= ST_BAD;
                    r_a    <= page_m;
                    r_k    <= OW'(i_req.order);
                    r_ford <= OW'(i_req.order);
                    r_fret <= S_FREE_END;
                end else if (i_req.cmd == CMD_ALLOC_AT) begin
                    r_p  <= page_m;
                    r_pk <= OW'(MAX_ORDER - 1);
                end else begin
                    r_st <= ST_BAD;
                end
            end
            S_SRCH: begin
                // One list entry read per cycle, compared in the cycle after its read.
                if (r_cv && i_mem_rd == r_tgt) begin
                    r_fnd  <= 1'b1;
                    r_fpos <= r_ci;
                end else if (r_si < cnt_rd) begin
                    r_ci <= IW'(r_si);
                    r_si <= r_si + CW'(1);
                    r_cv <= 1'b1;
                end else if (r_cv) begin
                    r_cv <= 1'b0;
                end else begin
                    r_fnd <= 1'b0;
                end
            end
            S_F_LOOP: begin
                r_sk   <= r_k;
                r_tgt  <= r_a ^ (ONE_FB << r_k);
                r_si   <= '0;
                r_cv   <= 1'b0;
                r_sret <= S_F_SRES;
            end
            S_F_SRES: begin
                if (r_fnd) begin
                    r_pos[r_k] <= r_fpos;
                    if (r_tgt < r_a) begin
                        r_a <= r_tgt;
                    end
                    r_k <= r_k + OW'(1);
                end
            end
            S_F_CHK: begin
                r_fst <= ST_FULL;
                r_j   <= r_ford;
            end
            S_F_RM: begin
                r_fst <= ST_OK;
            end
            S_F_RM2: begin
                r_j <= r_j + OW'(1);
            end
            S_FREE_END: begin
                r_st <= r_fst;
            end
            S_A_START: begin
                r_st <= ST_OOM;
                r_k  <= kf;
            end
            S_A_POP: begin
                r_a <= i_mem_rd;
            end
            S_A_SPL: begin
                if (r_k > r_ord) begin
                    r_k <= kk;
                end else begin
                    r_st  <= ST_OK;
                    r_res <= r_a;
                end
            end
            S_P_LOOP: begin
                r_base <= r_p & ~((ONE_FB << r_pk) - ONE_FB);
                r_tgt  <= r_p & ~((ONE_FB << r_pk) - ONE_FB);
                r_sk   <= r_pk;
                r_si   <= '0;
                r_cv   <= 1'b0;
                r_sret <= S_P_SRES;
            end
            S_P_SRES: begin
                if (r_fnd) begin
                    r_st <= ST_FULL;
                end else begin
                    r_st <= ST_NOTFREE;
                    r_pk <= r_pk - OW'(1);
                end
            end
            S_P_RM2: begin
                r_st <= ST_OK;
            end
            S_P_SPL: begin
                // Split one level: free the half that does not hold the page.
                if (r_pk != '0) begin
                    if (r_p >= upper) begin
                        r_a    <= r_base;
                        r_base <= upper;
                    end else begin
                        r_a <= upper;
                    end
                    r_k    <= kk;
                    r_ford <= kk;
                    r_pk   <= kk;
                    r_fret <= S_P_FRET;
                end else if (r_st == ST_OK) begin
                    r_res <= r_p;
                end
            end
            S_P_FRET: begin
                if (r_fst != ST_OK) begin
                    r_st <= ST_FULL;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_rsp_vld    = (r_state == S_DONE);
    assign o_rsp.status = r_st;
    assign o_rsp.page   = res_ext[PAGE_W-1:0];

endmodule

FILE: rtl/buddy_page_allocator_unit.sv
// ---------------------------------------------------------------------------
// Buddy page allocator
// Per-order free lists of page frames with split on allocate and buddy merge
// on free, held in one synchronous RAM and driven by a sequencer.
// ---------------------------------------------------------------------------
// Allocate pops the lowest non-empty list at or above the order and splits;
// free searches each order's list for the buddy, merging each buddy found;
// allocate-at adds one list search per order tried plus a free per split level.
// Throughput: one transaction at a time, set by the linear list search of
// the single RAM read port (one entry per cycle).
// Reset: synchronous, clears all list counts; no clearing pass.
`include "buddy_page_allocator_unit_defines.svh"

module buddy_page_allocator_unit #(
    parameter int MAX_ORDER  = bpa_pkg::MAX_ORDER_DEF,
    parameter int FRAME_BITS = bpa_pkg::FRAME_BITS_DEF,
    parameter int LIST_DEPTH = bpa_pkg::LIST_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bpa_pkg::CMD_W-1:0]      i_cmd,
    input  logic [bpa_pkg::PAGE_W-1:0]     i_page,
    input  logic [bpa_pkg::ORDER_W-1:0]    i_order,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bpa_pkg::STATUS_W-1:0]   o_status,
    output logic [bpa_pkg::PAGE_W-1:0]     o_result_page
);
    import bpa_pkg::*;

    localparam int OW    = $clog2(MAX_ORDER);
    localparam int IW    = $clog2(LIST_DEPTH);
    localparam int AW    = OW + IW;
    localparam int DEPTH = MAX_ORDER * (2 ** IW);

    t_req                  req;
    t_rsp                  rsp;
    logic                  start, busy, rsp_vld, rsp_take;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa, mem_ra;
    logic [FRAME_BITS-1:0] mem_wd, mem_rd;
    logic                  r_ovld;
    logic [STATUS_W-1:0]   r_ostat;
    logic [PAGE_W-1:0]     r_opage;

    // Input transaction is taken whenever the sequencer is idle.
    assign req.cmd   = i_cmd;
    assign req.page  = i_page;
    assign req.order = i_order;
    assign start      = i_in_valid && !o_in_stall;
    assign o_in_stall = busy;

    bpa_seq #(
        .MAX_ORDER  (MAX_ORDER),
        .FRAME_BITS (FRAME_BITS),
        .LIST_DEPTH (LIST_DEPTH),
        .OW         (OW),
        .IW         (IW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (req),
        .o_busy     (busy),
        .o_rsp_vld  (rsp_vld),
        .i_rsp_take (rsp_take),
        .o_rsp      (rsp),
        .o_mem_we   (mem_we),
        .o_mem_wa   (mem_wa),
        .o_mem_wd   (mem_wd),
        .o_mem_ra   (mem_ra),
        .i_mem_rd   (mem_rd)
    );

    bpa_list_mem #(
        .DW    (FRAME_BITS),
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk (i_clk),
        .i_we  (mem_we),
        .i_wa  (mem_wa),
        .i_wd  (mem_wd),
        .i_ra  (mem_ra),
        .o_rd  (mem_rd)
    );

    // Output register: loads a finished response when empty or draining.
    assign rsp_take = rsp_vld && (!r_ovld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (rsp_take) begin
            r_ovld <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_take) begin
            r_ostat <= rsp.status;
            r_opage <= rsp.page;
        end
    end

    assign o_out_valid   = r_ovld;
    assign o_status      = r_ostat;
    assign o_result_page = r_opage;

    // An accepted transaction always leaves the sequencer busy.
    `BPA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "not busy after accept")
    // A failed command never reports a page.
    `BPA_ASSERT_SAME(a_zero_page_on_error, o_out_valid && o_status != ST_OK, o_result_page == '0, "page on error")

endmodule
